### design/rgt_pkg.sv
// ----------------------------------------------------------------------------
// rgt_pkg: shared types and constants of the range grid triangulator
// Field widths of the request and result channels, configuration register
// indexes and the registered result record.
// ----------------------------------------------------------------------------
package rgt_pkg;

	// width of every vertex number field on the result channel
	localparam int FIELD_W = 24;

	// configuration register widths
	localparam int ROWS_REG_W  = 12;
	localparam int COLS_REG_W  = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;

	localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 12'd480;
	localparam logic [COLS_REG_W-1:0] COLS_RESET = 13'd640;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GRID_ROWS    = 1'b0,
		REG_GRID_COLUMNS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] vertex_number;
		logic               upper_face_valid;
		logic [FIELD_W-1:0] upper_face_first;
		logic [FIELD_W-1:0] upper_face_second;
		logic [FIELD_W-1:0] upper_face_third;
		logic               lower_face_valid;
		logic [FIELD_W-1:0] lower_face_first;
		logic [FIELD_W-1:0] lower_face_second;
		logic [FIELD_W-1:0] lower_face_third;
		logic               frame_last;
	} result_t;

endpackage

### design/rgt_stream_if.sv
// ----------------------------------------------------------------------------
// rgt_stream_if: request and result channels of the range grid triangulator
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rgt_point_if;
	logic valid;
	logic ready;
	logic point_valid;

	modport source (output valid, output point_valid, input ready);
	modport sink   (input valid, input point_valid, output ready);
endinterface

interface rgt_result_if;
	import rgt_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] vertex_number;
	logic               upper_face_valid;
	logic [FIELD_W-1:0] upper_face_first;
	logic [FIELD_W-1:0] upper_face_second;
	logic [FIELD_W-1:0] upper_face_third;
	logic               lower_face_valid;
	logic [FIELD_W-1:0] lower_face_first;
	logic [FIELD_W-1:0] lower_face_second;
	logic [FIELD_W-1:0] lower_face_third;
	logic               frame_last;

	modport source (
		output valid, input ready,
		output vertex_number,
		output upper_face_valid, output upper_face_first,
		output upper_face_second, output upper_face_third,
		output lower_face_valid, output lower_face_first,
		output lower_face_second, output lower_face_third,
		output frame_last
	);
	modport sink (
		input valid, output ready,
		input vertex_number,
		input upper_face_valid, input upper_face_first,
		input upper_face_second, input upper_face_third,
		input lower_face_valid, input lower_face_first,
		input lower_face_second, input lower_face_third,
		input frame_last
	);
endinterface

### design/rgt_ram.sv
// ----------------------------------------------------------------------------
// rgt_ram: generic single-write, single-read synchronous RAM
// Registered read, old data returned on a read of the address being written.
// ----------------------------------------------------------------------------
module rgt_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/range_grid_triangulator_core.sv
// ----------------------------------------------------------------------------
// range_grid_triangulator_core: range grid to triangle mesh
// Numbers the valid points of a column-major grid and emits, per point, the
// upper and lower triangles that close back onto the previous column.
// ----------------------------------------------------------------------------
// Use:
//  - points: one request per grid point (point_valid), column by column, each
//    column top to bottom. results: one result per request, in order.
//  - cfg_we/cfg_index/cfg_wdata: grid_rows (index 0) and grid_columns
//    (index 1); write only while the block is idle.
//  - Path: a taken request is registered in the line store read and stage 1;
//    it moves on into the output register once that slot is free or being
//    taken, and the result is offered from there.
//  - Throughput: one request per cycle unless results stall. Each request
//    reads the line store at its own row and the row below and writes its
//    own row in the same cycle; the store is held twice so both reads have their own port.
//  - Reset: grid_rows = 480, grid_columns = 640, vertex counter and grid
//    position cleared. The line store is not cleared: an entry is only read
//    after the same row of the previous column has written it.
//  - Stall: with results.ready low the block holds one finished result and
//    one request in flight, then drops points.ready until the result goes.
// ----------------------------------------------------------------------------
module range_grid_triangulator_core #(
	parameter int MAX_ROWS    = 2048,
	parameter int MAX_COLUMNS = 4096,
	parameter int INDEX_WIDTH = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rgt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rgt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	rgt_point_if.sink                     points,
	rgt_result_if.source                  results
);
	import rgt_pkg::*;

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLUMNS);
	// compare widths: hold the register value and the store depth alike
	localparam int RCMP_W = (($clog2(MAX_ROWS + 1) > ROWS_REG_W) ?
		$clog2(MAX_ROWS + 1) : ROWS_REG_W);
	localparam int CCMP_W = (($clog2(MAX_COLUMNS + 1) > COLS_REG_W) ?
		$clog2(MAX_COLUMNS + 1) : COLS_REG_W);

	// configuration
	logic [ROWS_REG_W-1:0] grid_rows_q;
	logic [COLS_REG_W-1:0] grid_columns_q;

	// frame position and numbering
	logic [ROW_W-1:0]       row_q;
	logic [COL_W-1:0]       col_q;
	logic [INDEX_WIDTH-1:0] vcnt_q;
	logic [INDEX_WIDTH-1:0] prev_num_q;

	// stage 1: request waiting on the line store read
	logic                   valid_s1;
	logic [INDEX_WIDTH-1:0] cur_s1;
	logic [INDEX_WIDTH-1:0] above_s1;
	logic                   col_gt0_s1;
	logic                   row_gt0_s1;
	logic                   last_row_s1;
	logic                   frame_last_s1;

	// output register
	logic    out_valid_q;
	result_t out_q;

	// handshakes
	logic in_acc;
	logic s1_adv;

	// request-side decode
	logic [RCMP_W-1:0]      rows_cfg;
	logic [RCMP_W-1:0]      rows_eff;
	logic [CCMP_W-1:0]      cols_cfg;
	logic [CCMP_W-1:0]      cols_eff;
	logic                   last_row;
	logic                   last_col;
	logic [INDEX_WIDTH-1:0] vcnt_inc;
	logic [INDEX_WIDTH-1:0] cur;
	logic [ROW_W-1:0]       row_below;

	// line store read data: own row and row below, previous column
	logic [INDEX_WIDTH-1:0] same_rd;
	logic [INDEX_WIDTH-1:0] next_rd;

	// face evaluation
	logic    up_face;
	logic    low_face;
	result_t res_d;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q    <= ROWS_RESET;
			grid_columns_q <= COLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_ROWS:    grid_rows_q    <= cfg_wdata[ROWS_REG_W-1:0];
				REG_GRID_COLUMNS: grid_columns_q <= cfg_wdata[COLS_REG_W-1:0];
			endcase
		end
	end

	// zero acts as one, anything above the store depth as the depth
	always_comb begin
		rows_cfg = RCMP_W'(grid_rows_q);
		cols_cfg = CCMP_W'(grid_columns_q);
		if (rows_cfg == '0) begin
			rows_eff = RCMP_W'(1);
		end else if (rows_cfg > RCMP_W'(MAX_ROWS)) begin
			rows_eff = RCMP_W'(MAX_ROWS);
		end else begin
			rows_eff = rows_cfg;
		end
		if (cols_cfg == '0) begin
			cols_eff = CCMP_W'(1);
		end else if (cols_cfg > CCMP_W'(MAX_COLUMNS)) begin
			cols_eff = CCMP_W'(MAX_COLUMNS);
		end else begin
			cols_eff = cols_cfg;
		end
	end

	// a position at or past the last row/column (after a shrink) is the last
	assign last_row = (RCMP_W'(row_q) + RCMP_W'(1)) >= rows_eff;
	assign last_col = (CCMP_W'(col_q) + CCMP_W'(1)) >= cols_eff;

	// saturating vertex counter
	assign vcnt_inc = (vcnt_q == '1) ? vcnt_q : vcnt_q + INDEX_WIDTH'(1);
	assign cur      = points.point_valid ? vcnt_inc : '0;

	assign row_below = (row_q == ROW_W'(MAX_ROWS - 1)) ? '0 : ROW_W'(row_q + ROW_W'(1));

	// ------------------------------------------------------------- handshakes
	assign s1_adv       = valid_s1 && (!out_valid_q || results.ready);
	assign points.ready = !valid_s1 || s1_adv;
	assign in_acc       = points.valid && points.ready;

	// ---------------------------------------------------------- frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			vcnt_q     <= '0;
			prev_num_q <= '0;
		end else if (in_acc) begin
			if (last_row) begin
				row_q <= '0;
				if (last_col) begin
					col_q      <= '0;
					vcnt_q     <= '0;
					prev_num_q <= '0;
				end else begin
					col_q      <= COL_W'(col_q + COL_W'(1));
					vcnt_q     <= points.point_valid ? vcnt_inc : vcnt_q;
					prev_num_q <= cur;
				end
			end else begin
				row_q      <= ROW_W'(row_q + ROW_W'(1));
				vcnt_q     <= points.point_valid ? vcnt_inc : vcnt_q;
				prev_num_q <= cur;
			end
		end
	end

	// ------------------------------------------------------------- line store
	// Written in the cycle the request is taken; the reads of the same cycle
	// return the old entry (previous column), later reads see the new one.
	rgt_ram #(
		.WIDTH (INDEX_WIDTH),
		.DEPTH (MAX_ROWS)
	) u_store_same (
		.clk   (clk),
		.we    (in_acc),
		.waddr (row_q),
		.wdata (cur),
		.re    (in_acc),
		.raddr (row_q),
		.rdata (same_rd)
	);

	rgt_ram #(
		.WIDTH (INDEX_WIDTH),
		.DEPTH (MAX_ROWS)
	) u_store_next (
		.clk   (clk),
		.we    (in_acc),
		.waddr (row_q),
		.wdata (cur),
		.re    (in_acc),
		.raddr (row_below),
		.rdata (next_rd)
	);

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_s1        <= cur;
			above_s1      <= prev_num_q;
			col_gt0_s1    <= (col_q != '0);
			row_gt0_s1    <= (row_q != '0);
			last_row_s1   <= last_row;
			frame_last_s1 <= last_row && last_col;
		end
	end

	// both faces need all three corners numbered
	assign up_face  = col_gt0_s1 && !last_row_s1 && (cur_s1 != '0) &&
		(same_rd != '0) && (next_rd != '0);
	assign low_face = col_gt0_s1 && row_gt0_s1 && (cur_s1 != '0) &&
		(same_rd != '0) && (above_s1 != '0);

	always_comb begin
		res_d                   = '0;
		res_d.vertex_number     = FIELD_W'(cur_s1);
		res_d.upper_face_valid  = up_face;
		res_d.lower_face_valid  = low_face;
		res_d.frame_last        = frame_last_s1;
		if (up_face) begin
			res_d.upper_face_first  = FIELD_W'(next_rd);
			res_d.upper_face_second = FIELD_W'(cur_s1);
			res_d.upper_face_third  = FIELD_W'(same_rd);
		end
		if (low_face) begin
			res_d.lower_face_first  = FIELD_W'(cur_s1);
			res_d.lower_face_second = FIELD_W'(above_s1);
			res_d.lower_face_third  = FIELD_W'(same_rd);
		end
	end

	// ---------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res_d;
		end
	end

	assign results.valid             = out_valid_q;
	assign results.vertex_number     = out_q.vertex_number;
	assign results.upper_face_valid  = out_q.upper_face_valid;
	assign results.upper_face_first  = out_q.upper_face_first;
	assign results.upper_face_second = out_q.upper_face_second;
	assign results.upper_face_third  = out_q.upper_face_third;
	assign results.lower_face_valid  = out_q.lower_face_valid;
	assign results.lower_face_first  = out_q.lower_face_first;
	assign results.lower_face_second = out_q.lower_face_second;
	assign results.lower_face_third  = out_q.lower_face_third;
	assign results.frame_last        = out_q.frame_last;

`ifndef SYNTHESIS
	// a taken request always lands in stage 1
	a_acc_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("request taken but stage 1 empty");

	// stage 1 never drops its request while the output slot is blocked
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !results.ready) |=> valid_s1)
		else $error("stage 1 lost a request under stall");

	// the end of a frame restarts position and numbering
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && last_row && last_col) |=>
		(row_q == '0 && col_q == '0 && vcnt_q == '0 && prev_num_q == '0))
		else $error("frame end did not restart the counters");

	// row position stays inside the line store
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		ROW_W'(MAX_ROWS - 1) >= row_q)
		else $error("row position beyond line store");

	// an emitted lower face never names an unnumbered corner
	a_face_corners: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.lower_face_valid) |->
		(out_q.lower_face_first != '0 && out_q.lower_face_second != '0 &&
		out_q.lower_face_third != '0))
		else $error("lower face with an invalid corner");
`endif

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for range_grid_triangulator_core
// Streams validity flags through the point channel under random idling and
// back-pressure, predicts vertex numbers and faces in lock-step, and checks
// every result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rgt_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int MAX_ROWS      = 2048;
	localparam int MAX_COLUMNS   = 4096;
	localparam int INDEX_WIDTH   = 24;
	localparam int ROW_W         = $clog2(MAX_ROWS);
	localparam int RANDOM_POINTS = 850;
	localparam int IDLE_PERCENT  = 22;
	// slack waited on top of the point where the block looks drained
	localparam int LATENCY_SLACK = 4;
	// longest honest gap is the receiver's hold below plus random idling
	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 80;
	localparam int HOLD_AT       = 50;
	localparam int CALM_FROM     = 300;
	localparam int CALM_TO       = 450;
	localparam int SHOWN_ERRORS  = 10;
	localparam int ROWS_REG_MAX  = 4095;
	localparam int COLS_REG_MAX  = 8191;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	rgt_point_if  pt();
	rgt_result_if rs();

	range_grid_triangulator_core #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS),
		.INDEX_WIDTH (INDEX_WIDTH)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.points    (pt),
		.results   (rs)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Mirror of the block: register copies, the line store of the previous
	// column, the running vertex count and the grid position of the next point.
	// ------------------------------------------------------------------------
	logic [ROWS_REG_W-1:0]  rows_reg;
	logic [COLS_REG_W-1:0]  cols_reg;
	logic [INDEX_WIDTH-1:0] line_numbers [MAX_ROWS];
	logic [INDEX_WIDTH-1:0] prev_number;
	logic [INDEX_WIDTH-1:0] vertex_count;
	int unsigned            row_pos;
	int unsigned            col_pos;

	logic    point_queue [$];     // requests still to be offered
	result_t expected_faces [$];  // predicted results, oldest first

	int   points_taken  = 0;
	int   results_taken = 0;
	int   face_errors   = 0;
	int   quiet_cycles  = 0;
	int   hold_left     = 0;
	bit   hold_done     = 1'b0;
	logic calm;

	// no random idling on either side inside this window of requests
	assign calm = (points_taken >= CALM_FROM) && (points_taken < CALM_TO);

	// a register of zero acts as one, anything past the store as its size
	function automatic int unsigned effective_size(input int unsigned v,
			input int unsigned lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	// Numbers one point and works out the two faces it closes back onto the
	// previous column; advances the mirrored position and line store.
	function automatic result_t triangulate_point(input logic lit);
		result_t                res;
		int unsigned            rows;
		int unsigned            cols;
		logic                   last_row;
		logic                   last_col;
		logic [INDEX_WIDTH-1:0] cur;
		logic [INDEX_WIDTH-1:0] same;
		logic [INDEX_WIDTH-1:0] next;
		logic                   up;
		logic                   low;
		rows = effective_size(rows_reg, MAX_ROWS);
		cols = effective_size(cols_reg, MAX_COLUMNS);
		// a position past a shrunken size counts as the last one
		last_row = (row_pos + 1 >= rows);
		last_col = (col_pos + 1 >= cols);
		cur  = '0;
		same = '0;
		next = '0;
		up   = 1'b0;
		low  = 1'b0;
		if (lit) begin
			// saturates rather than wrapping
			if (vertex_count != '1)
				vertex_count = vertex_count + 1'b1;
			cur = vertex_count;
		end
		if (col_pos > 0) begin
			same = line_numbers[ROW_W'(row_pos)];
			if (!last_row)
				next = line_numbers[ROW_W'(row_pos + 1)];
			up  = !last_row && cur != 0 && same != 0 && next != 0;
			low = row_pos > 0 && cur != 0 && same != 0 && prev_number != 0;
		end
		// faces not emitted leave their corners at zero
		res = '0;
		res.vertex_number = cur;
		if (up) begin
			res.upper_face_valid  = 1'b1;
			res.upper_face_first  = next;
			res.upper_face_second = cur;
			res.upper_face_third  = same;
		end
		if (low) begin
			res.lower_face_valid  = 1'b1;
			res.lower_face_first  = cur;
			res.lower_face_second = prev_number;
			res.lower_face_third  = same;
		end
		res.frame_last = last_row && last_col;
		line_numbers[ROW_W'(row_pos)] = cur;
		prev_number = cur;
		if (last_row) begin
			row_pos = 0;
			if (last_col) begin
				// frame done: numbering starts afresh
				col_pos      = 0;
				vertex_count = '0;
				prev_number  = '0;
			end else begin
				col_pos = col_pos + 1;
			end
		end else begin
			row_pos = row_pos + 1;
		end
		return res;
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("v=%0d up=%0b(%0d,%0d,%0d) low=%0b(%0d,%0d,%0d) last=%0b",
			r.vertex_number, r.upper_face_valid, r.upper_face_first,
			r.upper_face_second, r.upper_face_third, r.lower_face_valid,
			r.lower_face_first, r.lower_face_second, r.lower_face_third,
			r.frame_last);
	endfunction

	// ------------------------------------------------------------------------
	// Request driver: offers queued points, holds a request until taken, and
	// idles at random outside the calm window.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : point_driver
		logic idle_now;
		if (!arst_n) begin
			pt.valid       <= 1'b0;
			pt.point_valid <= 1'b0;
		end else begin
			if (pt.valid && pt.ready) begin
				expected_faces.push_back(triangulate_point(pt.point_valid));
				points_taken <= points_taken + 1;
			end
			idle_now = ($urandom_range(0, 99) < IDLE_PERCENT) && !calm;
			if (!pt.valid || pt.ready) begin
				if (point_queue.size() != 0 && !idle_now) begin
					pt.valid       <= 1'b1;
					pt.point_valid <= point_queue.pop_front();
				end else begin
					// payload is noise while nothing is offered
					pt.valid       <= 1'b0;
					pt.point_valid <= 1'($urandom_range(0, 1));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor: checks each taken result against the oldest prediction
	// and drives ready, including one long hold so the block fills and
	// pushes back on the request side.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		result_t got;
		result_t want;
		string   wrong;
		if (!arst_n) begin
			rs.ready <= 1'b0;
		end else begin
			if (rs.valid && rs.ready) begin
				got.vertex_number     = rs.vertex_number;
				got.upper_face_valid  = rs.upper_face_valid;
				got.upper_face_first  = rs.upper_face_first;
				got.upper_face_second = rs.upper_face_second;
				got.upper_face_third  = rs.upper_face_third;
				got.lower_face_valid  = rs.lower_face_valid;
				got.lower_face_first  = rs.lower_face_first;
				got.lower_face_second = rs.lower_face_second;
				got.lower_face_third  = rs.lower_face_third;
				got.frame_last        = rs.frame_last;
				if (expected_faces.size() == 0) begin
					face_errors++;
					if (face_errors <= SHOWN_ERRORS)
						$display("unexpected result %0d: %s", results_taken, describe(got));
				end else begin
					want  = expected_faces.pop_front();
					wrong = "";
					if (got.vertex_number !== want.vertex_number)
						wrong = {wrong, " vertex_number"};
					if (got.upper_face_valid !== want.upper_face_valid)
						wrong = {wrong, " upper_face_valid"};
					if (got.upper_face_first !== want.upper_face_first)
						wrong = {wrong, " upper_face_first"};
					if (got.upper_face_second !== want.upper_face_second)
						wrong = {wrong, " upper_face_second"};
					if (got.upper_face_third !== want.upper_face_third)
						wrong = {wrong, " upper_face_third"};
					if (got.lower_face_valid !== want.lower_face_valid)
						wrong = {wrong, " lower_face_valid"};
					if (got.lower_face_first !== want.lower_face_first)
						wrong = {wrong, " lower_face_first"};
					if (got.lower_face_second !== want.lower_face_second)
						wrong = {wrong, " lower_face_second"};
					if (got.lower_face_third !== want.lower_face_third)
						wrong = {wrong, " lower_face_third"};
					if (got.frame_last !== want.frame_last)
						wrong = {wrong, " frame_last"};
					if (wrong != "") begin
						face_errors++;
						if (face_errors <= SHOWN_ERRORS) begin
							$display("mismatch on result %0d:%s", results_taken, wrong);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
					end
				end
				results_taken++;
			end
			if (hold_left != 0) begin
				hold_left--;
				rs.ready <= 1'b0;
			end else if (!hold_done && points_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rs.ready <= 1'b0;
			end else begin
				rs.ready <= !(($urandom_range(0, 99) < IDLE_PERCENT) && !calm);
			end
		end
	end

	// watchdog: too long without any request or result moving
	always @(posedge clk) begin : watchdog
		if (!arst_n || (pt.valid && pt.ready) || (rs.valid && rs.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers. Registers change only with the block drained.
	// ------------------------------------------------------------------------
	task automatic wait_idle();
		@(negedge clk);
		while (point_queue.size() != 0 || pt.valid || expected_faces.size() != 0)
			@(negedge clk);
		repeat (LATENCY_SLACK) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		if (idx == REG_GRID_ROWS)
			rows_reg = ROWS_REG_W'(value);
		else
			cols_reg = COLS_REG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// queues n points, first one in bit 0, and waits for all results
	task automatic push_bits(input logic [31:0] bits, input int n);
		@(negedge clk);
		for (int i = 0; i < n; i++)
			point_queue.push_back(bits[i]);
		wait_idle();
	endtask

	initial begin : stimulus
		int unsigned random_points;
		int unsigned len;
		int unsigned density;
		int unsigned eff_rows;
		int unsigned pick;
		int unsigned new_size;
		bit          first_phase;

		arst_n         = 1'b0;
		pt.valid       = 1'b0;
		pt.point_valid = 1'b0;
		rs.ready       = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_GRID_ROWS;
		cfg_wdata      = '0;
		rows_reg       = ROWS_RESET;
		cols_reg       = COLS_RESET;
		prev_number    = '0;
		vertex_count   = '0;
		row_pos        = 0;
		col_pos        = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part --------------------------------------------------
		// reset sizes: a few points down the first column, one of them empty
		push_bits(32'b011, 3);
		// shrink rows mid-column: row 3 is past the new end, so it closes
		// column 0; two more columns of two give both kinds of face
		write_reg(REG_GRID_ROWS, 2);
		write_reg(REG_GRID_COLUMNS, 3);
		push_bits(32'b01111, 5);
		// zero sizes act as a 1x1 grid: every point is a whole frame
		write_reg(REG_GRID_ROWS, 0);
		write_reg(REG_GRID_COLUMNS, 0);
		push_bits(32'b01, 2);
		// registers above the store size, still in the first column
		write_reg(REG_GRID_ROWS, ROWS_REG_MAX);
		write_reg(REG_GRID_COLUMNS, COLS_REG_MAX);
		push_bits(32'b1011, 4);
		// shrink rows, then columns, mid-frame; the frame ends in column 2
		write_reg(REG_GRID_ROWS, 2);
		push_bits(32'b111, 3);
		write_reg(REG_GRID_COLUMNS, 2);
		push_bits(32'b11, 2);
		// exact maxima, then end the frame early with a single point
		write_reg(REG_GRID_ROWS, MAX_ROWS);
		write_reg(REG_GRID_COLUMNS, MAX_COLUMNS);
		push_bits(32'b101, 3);
		write_reg(REG_GRID_ROWS, 1);
		write_reg(REG_GRID_COLUMNS, 1);
		push_bits(32'b1, 1);

		// --- random part ----------------------------------------------------
		// Mostly small grids so frames close often; sizes change between
		// phases, sometimes mid-frame. Rows may only grow while in column 0,
		// otherwise a line store entry could be read before it is written.
		random_points = 0;
		first_phase   = 1'b1;
		while (random_points < RANDOM_POINTS) begin
			eff_rows = effective_size(rows_reg, MAX_ROWS);
			if (eff_rows > 16 || $urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 15);
				if (col_pos != 0)
					new_size = $urandom_range(0, (eff_rows < 9) ? eff_rows : 9);
				else if (pick == 0)
					new_size = 0;
				else if (pick == 1)
					new_size = MAX_ROWS;
				else if (pick == 2)
					new_size = ROWS_REG_MAX;
				else
					new_size = $urandom_range(1, 9);
				write_reg(REG_GRID_ROWS, new_size);
			end
			if ($urandom_range(0, 3) != 0) begin
				pick = $urandom_range(0, 15);
				if (pick == 0)
					new_size = 0;
				else if (pick == 1)
					new_size = MAX_COLUMNS;
				else if (pick == 2)
					new_size = COLS_REG_MAX;
				else
					new_size = $urandom_range(1, 9);
				write_reg(REG_GRID_COLUMNS, new_size);
			end
			// the first phase is long so the receiver's hold finds a full queue
			len = first_phase ? 100 : $urandom_range(8, 70);
			first_phase = 1'b0;
			case ($urandom_range(0, 4))
				0: density = 100;
				1: density = 90;
				2: density = 75;
				3: density = 50;
				default: density = 15;
			endcase
			@(negedge clk);
			repeat (len)
				point_queue.push_back($urandom_range(0, 99) < density);
			wait_idle();
			random_points += len;
		end

		// drained; give the pipeline a few more cycles to show strays
		repeat (LATENCY_SLACK) @(posedge clk);
		if (face_errors == 0 && expected_faces.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### sim.f
design/rgt_pkg.sv
design/rgt_stream_if.sv
design/rgt_ram.sv
design/range_grid_triangulator_core.sv
verif/tb.sv
